/* hw/rtl/sorted_priority_list_macros.svh */
// Assertion macros for the sorted priority list.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef SORTED_PRIORITY_LIST_MACROS_SVH
`define SORTED_PRIORITY_LIST_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SPL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SPL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/spl_pkg.sv */
// Shared types, codes and helpers for the sorted priority list.
// No dependencies.
package spl_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_BITS_DEF = 32;

    localparam int PRIO_W   = 4;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    localparam logic [PRIO_W-1:0] PRIO_MIN = 4'd1;
    localparam logic [PRIO_W-1:0] PRIO_MAX = 4'd10;

    // operation codes (s_tuser)
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_VIEW   = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    // status codes (m_tuser)
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    // per-cycle commands broadcast to every cell
    localparam logic [1:0] CMD_HOLD   = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_ROTATE = 2'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [PRIO_W-1:0] prio;
    } chain_ctl_t;

    typedef struct packed {
        logic any_hit;   // some occupied cell holds the key
        logic tail_hit;  // the last occupied cell holds the key
    } chain_stat_t;

    function automatic logic [PRIO_W-1:0] clamp_prio(input logic [PRIO_W-1:0] p);
        logic [PRIO_W-1:0] r;
        r = p;
        if (p < PRIO_MIN) r = PRIO_MIN;
        if (p > PRIO_MAX) r = PRIO_MAX;
        return r;
    endfunction

endpackage

/* hw/rtl/spl_cell.sv */
// One slot of the sorted list: holds a key and a priority, trades them
// with its neighbors. Depends on spl_pkg.
module spl_cell #(
    parameter int KEY_BITS = spl_pkg::KEY_BITS_DEF
) (
    input  logic                      aclk,
    input  spl_pkg::chain_ctl_t       ctl,
    input  logic [KEY_BITS-1:0]       new_key,
    input  logic                      occ,
    input  logic                      wrap_sel,
    input  logic [KEY_BITS-1:0]       left_key,
    input  logic [spl_pkg::PRIO_W-1:0] left_prio,
    input  logic                      left_ext,
    input  logic                      left_hit,
    input  logic [KEY_BITS-1:0]       right_key,
    input  logic [spl_pkg::PRIO_W-1:0] right_prio,
    input  logic [KEY_BITS-1:0]       head_key,
    input  logic [spl_pkg::PRIO_W-1:0] head_prio,
    output logic [KEY_BITS-1:0]       key,
    output logic [spl_pkg::PRIO_W-1:0] prio,
    output logic                      ext,
    output logic                      hit,
    output logic                      match
);

    logic [KEY_BITS-1:0]        key_reg, key_next;
    logic [spl_pkg::PRIO_W-1:0] prio_reg, prio_next;

    // ext: this slot sits at or behind the insertion point (free slots count)
    assign match = occ && (key_reg == new_key);
    assign ext   = !occ || (prio_reg > ctl.prio);
    assign hit   = left_hit || match;
    assign key   = key_reg;
    assign prio  = prio_reg;

    always_comb begin
        key_next  = key_reg;
        prio_next = prio_reg;
        case (ctl.cmd)
            spl_pkg::CMD_INSERT: begin
                if (ext && left_ext) begin
                    key_next  = left_key;
                    prio_next = left_prio;
                end else if (ext) begin
                    key_next  = new_key;
                    prio_next = ctl.prio;
                end
            end
            spl_pkg::CMD_REMOVE: begin
                if (hit) begin
                    key_next  = right_key;
                    prio_next = right_prio;
                end
            end
            spl_pkg::CMD_ROTATE: begin
                if (wrap_sel) begin
                    key_next  = head_key;
                    prio_next = head_prio;
                end else begin
                    key_next  = right_key;
                    prio_next = right_prio;
                end
            end
            default: begin
                key_next  = key_reg;
                prio_next = prio_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        prio_reg <= prio_next;
    end

endmodule

/* hw/rtl/spl_chain.sv */
// Row of spl_cell slots, front at index 0, with neighbor wiring and the
// occupancy decode from the entry count. Depends on spl_pkg, spl_cell.
module spl_chain #(
    parameter int CAPACITY = spl_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = spl_pkg::KEY_BITS_DEF,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic                       aclk,
    input  spl_pkg::chain_ctl_t        ctl,
    input  logic [KEY_BITS-1:0]        new_key,
    input  logic [CNT_W-1:0]           count,
    output spl_pkg::chain_stat_t       stat,
    output logic [KEY_BITS-1:0]        head_key,
    output logic [spl_pkg::PRIO_W-1:0] head_prio
);

    logic [KEY_BITS-1:0]        key_w  [CAPACITY];
    logic [spl_pkg::PRIO_W-1:0] prio_w [CAPACITY];
    logic [CAPACITY-1:0]        ext_w, hit_w, match_w, occ_w, wrap_w;

    assign head_key      = key_w[0];
    assign head_prio     = prio_w[0];
    assign stat.any_hit  = hit_w[CAPACITY-1];
    assign stat.tail_hit = |(match_w & wrap_w);

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [KEY_BITS-1:0]        lk, rk;
        logic [spl_pkg::PRIO_W-1:0] lp, rp;
        logic                       le, lh;

        assign occ_w[i]  = CNT_W'(i) < count;
        assign wrap_w[i] = CNT_W'(i + 1) == count;

        if (i == 0) begin : g_front
            assign lk = '0;
            assign lp = '0;
            assign le = 1'b0;
            assign lh = 1'b0;
        end else begin : g_mid
            assign lk = key_w[i-1];
            assign lp = prio_w[i-1];
            assign le = ext_w[i-1];
            assign lh = hit_w[i-1];
        end

        if (i == CAPACITY - 1) begin : g_back
            assign rk = key_w[i];
            assign rp = prio_w[i];
        end else begin : g_inner
            assign rk = key_w[i+1];
            assign rp = prio_w[i+1];
        end

        spl_cell #(
            .KEY_BITS(KEY_BITS)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .new_key   (new_key),
            .occ       (occ_w[i]),
            .wrap_sel  (wrap_w[i]),
            .left_key  (lk),
            .left_prio (lp),
            .left_ext  (le),
            .left_hit  (lh),
            .right_key (rk),
            .right_prio(rp),
            .head_key  (key_w[0]),
            .head_prio (prio_w[0]),
            .key       (key_w[i]),
            .prio      (prio_w[i]),
            .ext       (ext_w[i]),
            .hit       (hit_w[i]),
            .match     (match_w[i])
        );
    end

endmodule

/* hw/rtl/sorted_priority_list.sv */
// Sorted priority list: a chain of slot cells kept in ascending priority order.
// A new item is accepted every cycle that the result register is free and no
// view is in progress. View returns count items, one per cycle while the result
// register is free, by rotating the chain once through the front cell.
// Reset (aresetn low, synchronous) empties the list and the result register.
// Depends on spl_pkg, spl_chain, sorted_priority_list_macros.svh.
`include "sorted_priority_list_macros.svh"

module sorted_priority_list #(
    parameter int CAPACITY = spl_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = spl_pkg::KEY_BITS_DEF,
    localparam int CNT_W      = $clog2(CAPACITY + 1),
    localparam int IN_DATA_W  = ((KEY_BITS + spl_pkg::PRIO_W + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((KEY_BITS + spl_pkg::PRIO_W + CNT_W + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [IN_DATA_W-1:0]           s_tdata,   // key, priority_req
    input  logic [spl_pkg::OP_W-1:0]       s_tuser,   // op
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [OUT_DATA_W-1:0]          m_tdata,   // entry_key, entry_priority, position
    output logic [spl_pkg::STATUS_W-1:0]   m_tuser,   // status
    output logic                           m_tlast
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_VIEW = 1'b1;

    logic                          state_reg, state_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [CNT_W-1:0]              idx_reg, idx_next;
    logic                          ovalid_reg, ovalid_next;
    logic [spl_pkg::STATUS_W-1:0]  ostatus_reg, ostatus_next;
    logic [KEY_BITS-1:0]           okey_reg, okey_next;
    logic [spl_pkg::PRIO_W-1:0]    oprio_reg, oprio_next;
    logic [CNT_W-1:0]              opos_reg, opos_next;
    logic                          olast_reg, olast_next;

    logic                          out_free, in_acc;
    logic [KEY_BITS-1:0]           in_key;
    spl_pkg::chain_ctl_t           ctl;
    spl_pkg::chain_stat_t          stat;
    logic [KEY_BITS-1:0]           head_key;
    logic [spl_pkg::PRIO_W-1:0]    head_prio;

    assign out_free = !ovalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_acc   = s_tvalid && s_tready;
    assign in_key   = s_tdata[KEY_BITS-1:0];

    assign m_tvalid = ovalid_reg;
    assign m_tuser  = ostatus_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = OUT_DATA_W'({opos_reg, oprio_reg, okey_reg});

    spl_chain #(
        .CAPACITY(CAPACITY),
        .KEY_BITS(KEY_BITS)
    ) u_chain (
        .aclk     (aclk),
        .ctl      (ctl),
        .new_key  (in_key),
        .count    (count_reg),
        .stat     (stat),
        .head_key (head_key),
        .head_prio(head_prio)
    );

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        ovalid_next  = ovalid_reg && !m_tready;
        ostatus_next = ostatus_reg;
        okey_next    = okey_reg;
        oprio_next   = oprio_reg;
        opos_next    = opos_reg;
        olast_next   = olast_reg;
        ctl.cmd      = spl_pkg::CMD_HOLD;
        ctl.prio     = spl_pkg::clamp_prio(s_tdata[KEY_BITS +: spl_pkg::PRIO_W]);

        if (in_acc) begin
            // single-result ops: zero payload, last set
            ovalid_next  = 1'b1;
            ostatus_next = spl_pkg::ST_OK;
            okey_next    = '0;
            oprio_next   = '0;
            opos_next    = '0;
            olast_next   = 1'b1;
            case (s_tuser)
                spl_pkg::OP_INSERT: begin
                    if (count_reg == CNT_W'(CAPACITY)) begin
                        ostatus_next = spl_pkg::ST_FULL;
                    end else begin
                        ctl.cmd    = spl_pkg::CMD_INSERT;
                        count_next = count_reg + 1'b1;
                    end
                end
                spl_pkg::OP_REMOVE: begin
                    if (count_reg == '0) begin
                        ostatus_next = spl_pkg::ST_NOT_FOUND;
                    end else if (stat.tail_hit) begin
                        count_next = count_reg - 1'b1;
                    end else if (stat.any_hit) begin
                        ctl.cmd    = spl_pkg::CMD_REMOVE;
                        count_next = count_reg - 1'b1;
                    end else begin
                        ostatus_next = spl_pkg::ST_NOT_FOUND;
                    end
                end
                spl_pkg::OP_VIEW: begin
                    if (count_reg == '0) begin
                        ostatus_next = spl_pkg::ST_EMPTY;
                    end else begin
                        ovalid_next = 1'b0;
                        state_next  = ST_VIEW;
                        idx_next    = '0;
                    end
                end
                spl_pkg::OP_CLEAR: begin
                    count_next = '0;
                end
                default: begin
                    ostatus_next = spl_pkg::ST_OK;
                end
            endcase
        end else if (state_reg == ST_VIEW && out_free) begin
            // emit the front entry and rotate it to the back of the list
            ctl.cmd      = spl_pkg::CMD_ROTATE;
            ovalid_next  = 1'b1;
            ostatus_next = spl_pkg::ST_OK;
            okey_next    = head_key;
            oprio_next   = head_prio;
            opos_next    = idx_reg + 1'b1;
            olast_next   = (idx_reg + 1'b1) == count_reg;
            idx_next     = idx_reg + 1'b1;
            if ((idx_reg + 1'b1) == count_reg) begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ostatus_reg <= ostatus_next;
        okey_reg    <= okey_next;
        oprio_reg   <= oprio_next;
        opos_reg    <= opos_next;
        olast_reg   <= olast_next;
    end

    `SPL_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY), "entry count over capacity")
    `SPL_ASSERT_NOW(a_view_index, state_reg == ST_VIEW, idx_reg < count_reg, "view index past list end")
    `SPL_ASSERT_NEXT(a_insert_grows, in_acc && s_tuser == spl_pkg::OP_INSERT && count_reg != CNT_W'(CAPACITY), count_reg == $past(count_reg) + 1'b1, "insert did not add an entry")

endmodule

/* dv/sorted_priority_list_tb.sv */
// Self-checking testbench for sorted_priority_list: directed plan, then random traffic.
// Each item is checked against a shadow copy of the list kept in the bench.
// Depends on spl_pkg and the sorted_priority_list RTL.
module sorted_priority_list_tb;

    localparam int DEPTH        = spl_pkg::CAPACITY_DEF;
    localparam int KEY_W        = spl_pkg::KEY_BITS_DEF;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int IN_W         = ((KEY_W + spl_pkg::PRIO_W + 7) / 8) * 8;
    localparam int OUT_W        = ((KEY_W + spl_pkg::PRIO_W + CNT_W + 7) / 8) * 8;
    localparam int PLAN_ROWS    = 15;
    localparam int RANDOM_ITEMS = 282;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 60;

    typedef struct packed {
        logic [spl_pkg::STATUS_W-1:0] status;
        logic [KEY_W-1:0]             key;
        logic [spl_pkg::PRIO_W-1:0]   prio;
        logic [CNT_W-1:0]             pos;
        logic                         last;
    } reply_t;

    typedef struct packed {
        logic [KEY_W-1:0]           key;
        logic [spl_pkg::PRIO_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic [spl_pkg::OP_W-1:0]     op;
        logic [KEY_W-1:0]             key;
        logic [spl_pkg::PRIO_W-1:0]   prio;
        logic [4:0]                   reps;    // row repeats with key+k, prio+k
        logic                         typed;   // status below is the known answer
        logic [spl_pkg::STATUS_W-1:0] status;
    } plan_row_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [IN_W-1:0]              s_tdata;   // key, priority_req
    logic [spl_pkg::OP_W-1:0]     s_tuser;   // op
    logic                         m_tvalid;
    logic                         m_tready;
    logic [OUT_W-1:0]             m_tdata;   // entry_key, entry_priority, position
    logic [spl_pkg::STATUS_W-1:0] m_tuser;   // status
    logic                         m_tlast;

    entry_t           shadow_list[$];
    reply_t           due_replies[$];
    logic [KEY_W-1:0] key_pool[8];
    int               fail_count = 0;
    bit               quiet      = 1'b0;
    bit               hold_req   = 1'b0;

    plan_row_t plan [PLAN_ROWS] = '{
        '{spl_pkg::OP_VIEW,   32'h0000_0000, 4'd0,  5'd1,  1'b1, spl_pkg::ST_EMPTY},
        '{spl_pkg::OP_REMOVE, 32'h0000_0000, 4'd0,  5'd1,  1'b1, spl_pkg::ST_NOT_FOUND},
        '{spl_pkg::OP_CLEAR,  32'h0000_0000, 4'd0,  5'd1,  1'b1, spl_pkg::ST_OK},
        // priority 0 -> 1
        '{spl_pkg::OP_INSERT, 32'h0000_0000, 4'd0,  5'd1,  1'b1, spl_pkg::ST_OK},
        // priority 15 -> 10
        '{spl_pkg::OP_INSERT, 32'hFFFF_FFFF, 4'd15, 5'd1,  1'b1, spl_pkg::ST_OK},
        '{spl_pkg::OP_INSERT, 32'h0000_0005, 4'd10, 5'd1,  1'b0, spl_pkg::ST_OK},
        // lands behind key 0
        '{spl_pkg::OP_INSERT, 32'h0000_0006, 4'd1,  5'd1,  1'b0, spl_pkg::ST_OK},
        '{spl_pkg::OP_REMOVE, 32'h0000_1234, 4'd0,  5'd1,  1'b1, spl_pkg::ST_NOT_FOUND},
        '{spl_pkg::OP_VIEW,   32'h0000_0000, 4'd0,  5'd1,  1'b0, spl_pkg::ST_OK},
        // match in the middle, away from the tail
        '{spl_pkg::OP_REMOVE, 32'hFFFF_FFFF, 4'd0,  5'd1,  1'b0, spl_pkg::ST_OK},
        // match at the tail
        '{spl_pkg::OP_REMOVE, 32'h0000_0005, 4'd0,  5'd1,  1'b0, spl_pkg::ST_OK},
        // fill up
        '{spl_pkg::OP_INSERT, 32'hA000_0000, 4'd3,  5'd14, 1'b0, spl_pkg::ST_OK},
        '{spl_pkg::OP_INSERT, 32'hDEAD_BEEF, 4'd7,  5'd1,  1'b1, spl_pkg::ST_FULL},
        '{spl_pkg::OP_VIEW,   32'h0000_0000, 4'd0,  5'd1,  1'b0, spl_pkg::ST_OK},
        '{spl_pkg::OP_CLEAR,  32'h0000_0000, 4'd0,  5'd1,  1'b1, spl_pkg::ST_OK}
    };

    sorted_priority_list #(
        .CAPACITY (DEPTH),
        .KEY_BITS (KEY_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic void push_reply(logic [spl_pkg::STATUS_W-1:0] status,
                                       logic [KEY_W-1:0] key,
                                       logic [spl_pkg::PRIO_W-1:0] prio,
                                       logic [CNT_W-1:0] pos,
                                       logic last);
        reply_t r;
        r = '{status, key, prio, pos, last};
        due_replies.push_back(r);
    endfunction

    // Apply one accepted item to the shadow list and queue the replies it causes.
    function automatic void apply_to_shadow_list(logic [spl_pkg::OP_W-1:0] op,
                                                 logic [KEY_W-1:0] key,
                                                 logic [spl_pkg::PRIO_W-1:0] prio);
        entry_t                     e;
        logic [spl_pkg::PRIO_W-1:0] p;
        int                         at;
        int                         hit;
        case (op)
            spl_pkg::OP_INSERT: begin
                p = prio;
                if (p < spl_pkg::PRIO_MIN) p = spl_pkg::PRIO_MIN;
                if (p > spl_pkg::PRIO_MAX) p = spl_pkg::PRIO_MAX;
                if (shadow_list.size() >= DEPTH) begin
                    push_reply(spl_pkg::ST_FULL, '0, '0, '0, 1'b1);
                end else begin
                    at = shadow_list.size();
                    for (int i = 0; i < shadow_list.size(); i++) begin
                        if (shadow_list[i].prio > p) begin
                            at = i;
                            break;
                        end
                    end
                    e.key  = key;
                    e.prio = p;
                    shadow_list.insert(at, e);
                    push_reply(spl_pkg::ST_OK, '0, '0, '0, 1'b1);
                end
            end
            spl_pkg::OP_REMOVE: begin
                hit = -1;
                if (shadow_list.size() > 0) begin
                    // tail gets first look, then front-to-back
                    if (shadow_list[shadow_list.size() - 1].key == key) begin
                        hit = shadow_list.size() - 1;
                    end else begin
                        for (int i = 0; i < shadow_list.size(); i++) begin
                            if (shadow_list[i].key == key) begin
                                hit = i;
                                break;
                            end
                        end
                    end
                end
                if (hit < 0) begin
                    push_reply(spl_pkg::ST_NOT_FOUND, '0, '0, '0, 1'b1);
                end else begin
                    shadow_list.delete(hit);
                    push_reply(spl_pkg::ST_OK, '0, '0, '0, 1'b1);
                end
            end
            spl_pkg::OP_VIEW: begin
                if (shadow_list.size() == 0) begin
                    push_reply(spl_pkg::ST_EMPTY, '0, '0, '0, 1'b1);
                end else begin
                    for (int i = 0; i < shadow_list.size(); i++) begin
                        push_reply(spl_pkg::ST_OK, shadow_list[i].key, shadow_list[i].prio,
                                   CNT_W'(i + 1), i == shadow_list.size() - 1);
                    end
                end
            end
            default: begin
                shadow_list.delete();
                push_reply(spl_pkg::ST_OK, '0, '0, '0, 1'b1);
            end
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] pick_key(bit for_remove);
        int sel;
        sel = $urandom_range(99);
        if (for_remove && shadow_list.size() > 0 && sel < 60)
            return shadow_list[$urandom_range(shadow_list.size() - 1)].key;
        if (sel < 75)
            return key_pool[$urandom_range(7)];
        return $urandom();
    endfunction

    task automatic send_item(logic [spl_pkg::OP_W-1:0] op, logic [KEY_W-1:0] key,
                             logic [spl_pkg::PRIO_W-1:0] prio, logic typed,
                             logic [spl_pkg::STATUS_W-1:0] status);
        reply_t known;
        while (!quiet && $urandom_range(99) < 14) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= IN_W'({prio, key});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        apply_to_shadow_list(op, key, prio);
        if (typed) begin
            known = '{status, '0, '0, '0, 1'b1};
            void'(due_replies.pop_back());
            due_replies.push_back(known);
        end
    endtask

    task automatic check_reply();
        reply_t got;
        reply_t want;
        got = '{m_tuser, m_tdata[KEY_W-1:0], m_tdata[KEY_W +: spl_pkg::PRIO_W],
                m_tdata[KEY_W + spl_pkg::PRIO_W +: CNT_W], m_tlast};
        if (due_replies.size() == 0) begin
            $display("%0t: unexpected item status=%0d key=%h prio=%0d pos=%0d last=%0d",
                     $time, got.status, got.key, got.prio, got.pos, got.last);
            fail_count++;
        end else begin
            want = due_replies.pop_front();
            if (got !== want) begin
                $display("%0t: mismatch exp status=%0d key=%h prio=%0d pos=%0d last=%0d",
                         $time, want.status, want.key, want.prio, want.pos, want.last);
                $display("%0t:          got status=%0d key=%h prio=%0d pos=%0d last=%0d",
                         $time, got.status, got.key, got.prio, got.pos, got.last);
                fail_count++;
            end
        end
    endtask

    // stimulus
    initial begin
        int                         r;
        logic [spl_pkg::OP_W-1:0]   op;
        logic [KEY_W-1:0]           key;
        logic [spl_pkg::PRIO_W-1:0] prio;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= spl_pkg::OP_INSERT;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 8; i++) key_pool[i] = $urandom();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int row = 0; row < PLAN_ROWS; row++) begin
            for (int k = 0; k < plan[row].reps; k++) begin
                send_item(plan[row].op, plan[row].key + KEY_W'(k),
                          spl_pkg::PRIO_W'(plan[row].prio + k), plan[row].typed,
                          plan[row].status);
            end
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet = (n >= 230 && n < 290);
            if (n == 80) hold_req = 1'b1;
            if (n == 160) begin
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (due_replies.size() != 0);
            end
            r = $urandom_range(99);
            if (r < 45)      op = spl_pkg::OP_INSERT;
            else if (r < 75) op = spl_pkg::OP_REMOVE;
            else if (r < 92) op = spl_pkg::OP_VIEW;
            else             op = spl_pkg::OP_CLEAR;
            key  = pick_key(op == spl_pkg::OP_REMOVE);
            prio = ($urandom_range(4) == 0) ? spl_pkg::PRIO_W'($urandom_range(15))
                                            : spl_pkg::PRIO_W'($urandom_range(10, 1));
            send_item(op, key, prio, 1'b0, spl_pkg::ST_OK);
        end
        quiet = 1'b0;

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (due_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // result side
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                // long back-pressure so the result register stays full and the block stalls its input
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= quiet || ($urandom_range(99) >= 14);
                @(posedge aclk);
                if (m_tvalid && m_tready) check_reply();
            end
        end
    end

    initial begin
        #3_200_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/spl_pkg.sv
hw/rtl/spl_cell.sv
hw/rtl/spl_chain.sv
hw/rtl/sorted_priority_list.sv
dv/sorted_priority_list_tb.sv
